// ===== rtl/tflb_pkg.sv =====
package tflb_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int CH_W       = 16;
  localparam int NUM_CH     = 4;
  localparam int POS_W      = 17;
  localparam int SEG_W      = 9;
  localparam int DIV_STEPS  = CH_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // channel order: opacity, red, green, blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] chan_vec_t;
  typedef logic [NUM_CH*CH_W-1:0]      entry_t;

endpackage

// ===== rtl/transfer_function_lut_builder_unit.sv =====
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall    cmd, position, point color/opacity, lookup_index
// out_     output     out_valid / out_stall  opacity, red, green, blue, hit, filled_entries
//
// Lookup: table read, then output register. Table is one 256 x 64 sync RAM.
// Add with no new entries loads the output register directly. Add that closes a segment
// of n entries sets up per-channel quotient and remainder with a radix-2 divider, then
// writes min(n, free entries) entries, one entry per cycle.
// Reset (rst_n low, synchronous) empties the table count and forgets the last point.
// A new item is taken only when the unit is idle and its output register is empty or
// being transferred in the same cycle; out_stall holds the result in place.
module transfer_function_lut_builder_unit
  import tflb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [POS_W-1:0]        in_position,
  input  logic [CH_W-1:0]         in_point_opacity,
  input  logic [CH_W-1:0]         in_point_red,
  input  logic [CH_W-1:0]         in_point_green,
  input  logic [CH_W-1:0]         in_point_blue,
  input  logic [ADDR_W-1:0]       in_lookup_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         out_opacity,
  output logic [CH_W-1:0]         out_red,
  output logic [CH_W-1:0]         out_green,
  output logic [CH_W-1:0]         out_blue,
  output logic                    out_hit,
  output logic [CNT_W-1:0]        out_filled_entries
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FILL = 2'd3;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [POS_W-1:0]  prev_pos_r, prev_pos_nxt;
  chan_vec_t         prev_ch_r, prev_ch_nxt;
  chan_vec_t         base_r, base_nxt;
  logic [NUM_CH-1:0] neg_r, neg_nxt;
  chan_vec_t         dvd_r, dvd_nxt;       // dividend, shifts into quotient
  logic [NUM_CH-1:0][SEG_W-1:0] rem_r, rem_nxt;
  logic [SEG_W-1:0]  n_r, n_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SEG_W-1:0]  j_r, j_nxt;
  chan_vec_t         acc_q_r, acc_q_nxt;
  logic [NUM_CH-1:0][SEG_W-1:0] acc_r_r, acc_r_nxt;
  logic              hit_r, hit_nxt;

  logic              out_valid_r, out_valid_nxt;
  chan_vec_t         out_ch_r, out_ch_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  entry_t            mem [TABLE_SIZE];
  entry_t            rd_data_r;
  entry_t            wr_data;
  logic              mem_we;
  logic              mem_re;

  chan_vec_t         pt_ch;
  chan_vec_t         rd_ch;
  logic              accept;
  logic              out_free;
  logic [POS_W-1:0]  dx;
  logic [SEG_W-1:0]  seg_n;
  logic              seg_go;
  logic              fill_last;

  logic [SEG_W:0]    rem_t   [NUM_CH];
  logic              rem_ge  [NUM_CH];
  logic [SEG_W:0]    acc_sum [NUM_CH];
  logic              acc_ge  [NUM_CH];

  assign pt_ch    = {in_point_opacity, in_point_red, in_point_green, in_point_blue};
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  assign dx     = in_position - prev_pos_r;
  assign seg_n  = dx[POS_W-1:POS_W-SEG_W];
  assign seg_go = have_prev_r && (in_position > prev_pos_r) && (seg_n != '0) &&
                  (fill_cnt_r != CNT_FULL);

  assign fill_last = (j_r == n_r - SEG_W'(1)) || (fill_cnt_r == CNT_LAST);

  assign mem_we = (state_r == S_FILL);
  assign mem_re = accept && (in_cmd == CMD_LOOKUP);
  assign rd_ch  = rd_data_r;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      rem_t[k]   = {rem_r[k], dvd_r[k][CH_W-1]};
      rem_ge[k]  = rem_t[k] >= {1'b0, n_r};
      acc_sum[k] = {1'b0, acc_r_r[k]} + {1'b0, rem_r[k]};
      acc_ge[k]  = acc_sum[k] >= {1'b0, n_r};
      wr_data[(NUM_CH-1-k)*CH_W +: CH_W] = neg_r[NUM_CH-1-k] ?
          base_r[NUM_CH-1-k] - acc_q_r[NUM_CH-1-k] :
          base_r[NUM_CH-1-k] + acc_q_r[NUM_CH-1-k];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    have_prev_nxt = have_prev_r;
    prev_pos_nxt  = prev_pos_r;
    prev_ch_nxt   = prev_ch_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    step_nxt      = step_r;
    j_nxt         = j_r;
    acc_q_nxt     = acc_q_r;
    acc_r_nxt     = acc_r_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ch_nxt    = out_ch_r;
    out_hit_nxt   = out_hit_r;
    out_cnt_nxt   = out_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LOOKUP) begin
            hit_nxt   = {1'b0, in_lookup_index} < fill_cnt_r;
            state_nxt = S_LOOK;
          end else begin
            have_prev_nxt = 1'b1;
            prev_pos_nxt  = in_position;
            prev_ch_nxt   = pt_ch;
            base_nxt      = prev_ch_r;
            n_nxt         = seg_n;
            step_nxt      = '0;
            for (int k = 0; k < NUM_CH; k++) begin
              neg_nxt[k] = pt_ch[k] < prev_ch_r[k];
              dvd_nxt[k] = neg_nxt[k] ? prev_ch_r[k] - pt_ch[k] : pt_ch[k] - prev_ch_r[k];
              rem_nxt[k] = '0;
            end
            if (seg_go) begin
              state_nxt = S_DIV;
            end else begin
              out_valid_nxt = 1'b1;
              out_ch_nxt    = '0;
              out_hit_nxt   = 1'b0;
              out_cnt_nxt   = fill_cnt_r;
            end
          end
        end
      end
      S_LOOK: begin
        out_valid_nxt = 1'b1;
        out_ch_nxt    = hit_r ? rd_ch : '0;
        out_hit_nxt   = hit_r;
        out_cnt_nxt   = fill_cnt_r;
        state_nxt     = S_IDLE;
      end
      S_DIV: begin
        for (int k = 0; k < NUM_CH; k++) begin
          rem_nxt[k] = rem_ge[k] ? SEG_W'(rem_t[k] - {1'b0, n_r}) : rem_t[k][SEG_W-1:0];
          dvd_nxt[k] = {dvd_r[k][CH_W-2:0], rem_ge[k]};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          j_nxt     = '0;
          acc_q_nxt = '0;
          acc_r_nxt = '0;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        // dvd_r holds |diff| / n, rem_r the remainder; acc tracks j*|diff| / n
        for (int k = 0; k < NUM_CH; k++) begin
          if (acc_ge[k]) begin
            acc_r_nxt[k] = SEG_W'(acc_sum[k] - {1'b0, n_r});
            acc_q_nxt[k] = acc_q_r[k] + dvd_r[k] + CH_W'(1);
          end else begin
            acc_r_nxt[k] = acc_sum[k][SEG_W-1:0];
            acc_q_nxt[k] = acc_q_r[k] + dvd_r[k];
          end
        end
        j_nxt        = j_r + SEG_W'(1);
        fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
        if (fill_last) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = '0;
          out_hit_nxt   = 1'b0;
          out_cnt_nxt   = fill_cnt_nxt;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_cnt_r  <= '0;
      have_prev_r <= 1'b0;
      prev_pos_r  <= '0;
      prev_ch_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      have_prev_r <= have_prev_nxt;
      prev_pos_r  <= prev_pos_nxt;
      prev_ch_r   <= prev_ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    neg_r     <= neg_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    n_r       <= n_nxt;
    step_r    <= step_nxt;
    j_r       <= j_nxt;
    acc_q_r   <= acc_q_nxt;
    acc_r_r   <= acc_r_nxt;
    hit_r     <= hit_nxt;
    out_ch_r  <= out_ch_nxt;
    out_hit_r <= out_hit_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_cnt_r[ADDR_W-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[in_lookup_index];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_opacity        = out_ch_r[3];
  assign out_red            = out_ch_r[2];
  assign out_green          = out_ch_r[1];
  assign out_blue           = out_ch_r[0];
  assign out_hit            = out_hit_r;
  assign out_filled_entries = out_cnt_r;

endmodule

// ===== test/transfer_function_lut_builder_unit_tb.sv =====
`timescale 1ns / 100ps

module transfer_function_lut_builder_unit_tb
  import tflb_pkg::*;
;

  localparam int MAX_POS      = (1 << POS_W) - 1;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic              cmd;
    logic [POS_W-1:0]  position;
    chan_vec_t         point;
    logic [ADDR_W-1:0] lookup_index;
  } tf_item_t;

  typedef struct packed {
    chan_vec_t        chans;
    logic             hit;
    logic [CNT_W-1:0] filled;
  } tf_result_t;

  // Tracks the table contents and the queue of lookup/add responses still owed.
  class tf_scoreboard;
    chan_vec_t    lut [TABLE_SIZE];
    int unsigned  fill_cnt;
    bit           have_prev;
    int unsigned  prev_pos;
    chan_vec_t    prev_pt;
    tf_result_t   owed_q [$];
    int unsigned  errors;
    string        chan_name [NUM_CH];

    function new();
      fill_cnt  = 0;
      have_prev = 0;
      prev_pos  = 0;
      prev_pt   = '0;
      errors    = 0;
      chan_name = '{"opacity", "red", "green", "blue"};
    endfunction

    // start + trunc(j * (end - start) / n), division rounding toward zero
    function logic [CH_W-1:0] interp(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                     int unsigned j, int unsigned n);
      longint sa, sb, lj, ln, off;
      sa  = longint'(a);
      sb  = longint'(b);
      lj  = longint'(j);
      ln  = longint'(n);
      off = (lj * (sb - sa)) / ln;
      return CH_W'(sa + off);
    endfunction

    function void note_input(tf_item_t it);
      tf_result_t  r;
      int unsigned seg_n;
      r = '0;
      if (it.cmd == CMD_ADD) begin
        if (have_prev && it.position > prev_pos) begin
          seg_n = ((it.position - prev_pos) * 256) >> 16;
          for (int unsigned j = 0; j < seg_n && fill_cnt < TABLE_SIZE; j++) begin
            for (int k = 0; k < NUM_CH; k++)
              lut[fill_cnt][k] = interp(prev_pt[k], it.point[k], j, seg_n);
            fill_cnt++;
          end
        end
        prev_pos  = it.position;
        prev_pt   = it.point;
        have_prev = 1;
      end else if (it.lookup_index < fill_cnt) begin
        r.chans = lut[it.lookup_index];
        r.hit   = 1'b1;
      end
      r.filled = CNT_W'(fill_cnt);
      owed_q.push_back(r);
    endfunction

    task flag_mismatch(string what, longint seen, longint want);
      if (errors < MAX_PRINTS)
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, seen, want);
      errors++;
    endtask

    task check_result(tf_result_t got);
      tf_result_t want;
      if (owed_q.size() == 0) begin
        flag_mismatch("unexpected transfer on out_, filled_entries",
                      longint'(got.filled), longint'(0));
        return;
      end
      want = owed_q.pop_front();
      for (int k = 0; k < NUM_CH; k++)
        if (got.chans[k] !== want.chans[k])
          flag_mismatch(chan_name[k], longint'(got.chans[k]), longint'(want.chans[k]));
      if (got.hit !== want.hit)
        flag_mismatch("hit", longint'(got.hit), longint'(want.hit));
      if (got.filled !== want.filled)
        flag_mismatch("filled_entries", longint'(got.filled), longint'(want.filled));
    endtask

    function int pending_count();
      return owed_q.size();
    endfunction

    task final_check();
      tf_result_t left;
      while (owed_q.size() != 0) begin
        left = owed_q.pop_front();
        flag_mismatch("result never arrived, filled_entries",
                      longint'(0), longint'(left.filled));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_cmd;
  logic [POS_W-1:0]    in_position;
  logic [CH_W-1:0]     in_point_opacity;
  logic [CH_W-1:0]     in_point_red;
  logic [CH_W-1:0]     in_point_green;
  logic [CH_W-1:0]     in_point_blue;
  logic [ADDR_W-1:0]   in_lookup_index;
  logic                out_valid;
  logic                out_stall;
  logic [CH_W-1:0]     out_opacity;
  logic [CH_W-1:0]     out_red;
  logic [CH_W-1:0]     out_green;
  logic [CH_W-1:0]     out_blue;
  logic                out_hit;
  logic [CNT_W-1:0]    out_filled_entries;

  tf_scoreboard sb;
  int           send_idle_pct = 36;
  int           recv_idle_pct = 46;
  bit           pressure_req  = 0;
  bit           pressure_done = 0;
  int unsigned  gen_prev      = 0;
  bit           gen_has_prev  = 0;
  int unsigned  gen_fill      = 0;
  int unsigned  quiet_cycles  = 0;

  transfer_function_lut_builder_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_point_opacity   (in_point_opacity),
    .in_point_red       (in_point_red),
    .in_point_green     (in_point_green),
    .in_point_blue      (in_point_blue),
    .in_lookup_index    (in_lookup_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_opacity        (out_opacity),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_hit            (out_hit),
    .out_filled_entries (out_filled_entries)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function chan_vec_t pt4(int o, int r, int g, int b);
    chan_vec_t p;
    p[0] = CH_W'(o);
    p[1] = CH_W'(r);
    p[2] = CH_W'(g);
    p[3] = CH_W'(b);
    return p;
  endfunction

  function chan_vec_t rand_point();
    chan_vec_t p;
    for (int k = 0; k < NUM_CH; k++)
      case ($urandom_range(9))
        0: p[k] = '0;
        1: p[k] = '1;
        default: p[k] = CH_W'($urandom_range(16'hFFFF));
      endcase
    return p;
  endfunction

  function tf_item_t add_item(int unsigned pos, chan_vec_t p);
    tf_item_t it;
    it              = '0;
    it.cmd          = CMD_ADD;
    it.position     = POS_W'(pos);
    it.point        = p;
    it.lookup_index = ADDR_W'($urandom_range(255));
    return it;
  endfunction

  function tf_item_t lookup_item(int unsigned idx);
    tf_item_t it;
    it              = '0;
    it.cmd          = CMD_LOOKUP;
    it.position     = POS_W'($urandom_range(MAX_POS));
    it.point        = rand_point();
    it.lookup_index = ADDR_W'(idx);
    return it;
  endfunction

  // Presents one item and returns at the edge where it transfers.
  task automatic drive_item(input tf_item_t it);
    int unsigned seg_n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= it.cmd;
    in_position      <= it.position;
    in_point_opacity <= it.point[0];
    in_point_red     <= it.point[1];
    in_point_green   <= it.point[2];
    in_point_blue    <= it.point[3];
    in_lookup_index  <= it.lookup_index;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // rough fill estimate used only to steer stimulus
    if (it.cmd == CMD_ADD) begin
      if (gen_has_prev && it.position > gen_prev) begin
        seg_n    = ((it.position - gen_prev) * 256) >> 16;
        gen_fill = (gen_fill + seg_n > TABLE_SIZE) ? TABLE_SIZE : gen_fill + seg_n;
      end
      gen_prev     = it.position;
      gen_has_prev = 1;
    end
  endtask

  task automatic run_directed();
    drive_item(lookup_item(0));
    drive_item(lookup_item(255));
    drive_item(add_item(1000, pt4(0, 16'hFFFF, 16'h1234, 16'hFFFF)));
    drive_item(add_item(1000, pt4(1, 2, 3, 4)));
    drive_item(add_item(500, pt4(16'hFFFF, 0, 100, 7)));
    drive_item(add_item(700, pt4(16'hFFFF, 0, 100, 7)));
    // three-entry ramp, falling channels exercise truncation toward zero
    drive_item(add_item(1500, pt4(0, 16'hFFFF, 0, 0)));
    drive_item(lookup_item(0));
    drive_item(lookup_item(1));
    drive_item(lookup_item(2));
    drive_item(lookup_item(3));
    drive_item(add_item(1756, pt4(16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555)));
    drive_item(lookup_item(3));
    drive_item(add_item(1755, rand_point()));
    drive_item(add_item(2011, rand_point()));
    drive_item(lookup_item(4));
    drive_item(lookup_item(5));
    drive_item(lookup_item(128));
  endtask

  task automatic run_random(input int count);
    int unsigned pos, roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        if (gen_fill > 0 && $urandom_range(99) < 75)
          drive_item(lookup_item($urandom_range(gen_fill - 1)));
        else
          drive_item(lookup_item($urandom_range(255)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          pos = $urandom_range(gen_prev, 0);
        end else begin
          // keep most segments short so the table fills slowly
          pos = gen_prev + ((roll < 20 && gen_fill < 230) ? $urandom_range(1279, 256)
                                                          : $urandom_range(255, 1));
          if (pos > MAX_POS)
            pos = $urandom_range(gen_prev, 0);
        end
        drive_item(add_item(pos, rand_point()));
      end
    end
  endtask

  task automatic run_fill_out();
    drive_item(add_item(0, rand_point()));
    drive_item(add_item(MAX_POS, rand_point()));
    drive_item(add_item(0, rand_point()));
    drive_item(add_item(65536, rand_point()));
    drive_item(lookup_item(255));
    drive_item(lookup_item(0));
    repeat (30) drive_item(lookup_item($urandom_range(255)));
  endtask

  // receiver side
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req && !pressure_done) begin
        pressure_done = 1;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    tf_item_t seen;
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0) begin
      seen.cmd          = in_cmd;
      seen.position     = in_position;
      seen.point[0]     = in_point_opacity;
      seen.point[1]     = in_point_red;
      seen.point[2]     = in_point_green;
      seen.point[3]     = in_point_blue;
      seen.lookup_index = in_lookup_index;
      sb.note_input(seen);
    end
  end

  always @(posedge clk) begin
    tf_result_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.chans[0] = out_opacity;
      got.chans[1] = out_red;
      got.chans[2] = out_green;
      got.chans[3] = out_blue;
      got.hit      = out_hit;
      got.filled   = out_filled_entries;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("transfer_function_lut_builder_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_cmd           <= CMD_ADD;
    in_position      <= '0;
    in_point_opacity <= '0;
    in_point_red     <= '0;
    in_point_green   <= '0;
    in_point_blue    <= '0;
    in_lookup_index  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(567);
    send_idle_pct = 46;
    recv_idle_pct = 36;
    run_random(567);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_req  = 1;
    run_random(520);
    run_fill_out();
    in_valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.final_check();
    if (sb.errors == 0)
      $display("transfer_function_lut_builder_unit regression: pass");
    else
      $display("transfer_function_lut_builder_unit regression: fail");
    $finish;
  end

endmodule
